// ===== sv/ard_pkg.sv =====
// Shared types, codes and the Pearson permutation table for the archive record deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package ard_pkg;

    localparam logic [7:0] MAGIC_BYTE = 8'h42;
    localparam logic [3:0] HDR_LAST   = 4'd10;
    localparam logic [3:0] HDR_MODE_N = 4'd3;
    localparam logic [3:0] HDR_PLEN_N = 4'd5;
    localparam logic [23:0] TYPE_MASK = 24'o170000;
    localparam logic [23:0] TYPE_DIR  = 24'o040000;

    localparam logic [2:0] KIND_MAGIC   = 3'd0;
    localparam logic [2:0] KIND_HEADER  = 3'd1;
    localparam logic [2:0] KIND_PATH    = 3'd2;
    localparam logic [2:0] KIND_CONTENT = 3'd3;
    localparam logic [2:0] KIND_TRAILER = 3'd4;
    localparam logic [2:0] KIND_DROP    = 3'd5;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_MAGIC = 2'd1;
    localparam logic [1:0] ERR_HASH  = 2'd2;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_HEADER,
        PH_PATH,
        PH_CONTENT,
        PH_TRAILER,
        PH_ERROR
    } t_phase;

    typedef struct packed {
        logic [2:0]  byte_kind;
        logic [7:0]  byte_value;
        logic [23:0] record_mode;
        logic [15:0] path_len;
        logic [47:0] content_len;
        logic        is_directory;
        logic        hash_match;
        logic [7:0]  computed_hash;
        logic [1:0]  error_code;
    } t_result;

    localparam logic [7:0] PEARSON_ROM [256] = '{
        8'd241, 8'd18,  8'd181, 8'd164, 8'd92,  8'd237, 8'd100, 8'd216,
        8'd183, 8'd107, 8'd2,   8'd12,  8'd43,  8'd246, 8'd90,  8'd143,
        8'd251, 8'd49,  8'd228, 8'd134, 8'd215, 8'd20,  8'd193, 8'd172,
        8'd140, 8'd227, 8'd148, 8'd118, 8'd57,  8'd72,  8'd119, 8'd174,
        8'd78,  8'd14,  8'd97,  8'd3,   8'd208, 8'd252, 8'd11,  8'd195,
        8'd31,  8'd28,  8'd121, 8'd206, 8'd149, 8'd23,  8'd83,  8'd154,
        8'd223, 8'd109, 8'd89,  8'd10,  8'd178, 8'd243, 8'd42,  8'd194,
        8'd221, 8'd131, 8'd212, 8'd94,  8'd205, 8'd240, 8'd161, 8'd7,
        8'd62,  8'd214, 8'd222, 8'd219, 8'd1,   8'd84,  8'd95,  8'd58,
        8'd103, 8'd60,  8'd33,  8'd111, 8'd188, 8'd218, 8'd186, 8'd166,
        8'd146, 8'd189, 8'd201, 8'd155, 8'd68,  8'd145, 8'd44,  8'd163,
        8'd69,  8'd196, 8'd115, 8'd231, 8'd61,  8'd157, 8'd165, 8'd213,
        8'd139, 8'd112, 8'd173, 8'd191, 8'd142, 8'd88,  8'd106, 8'd250,
        8'd8,   8'd127, 8'd26,  8'd126, 8'd0,   8'd96,  8'd52,  8'd182,
        8'd113, 8'd38,  8'd242, 8'd48,  8'd204, 8'd160, 8'd15,  8'd54,
        8'd158, 8'd192, 8'd81,  8'd125, 8'd245, 8'd239, 8'd101, 8'd17,
        8'd136, 8'd110, 8'd24,  8'd53,  8'd132, 8'd117, 8'd102, 8'd153,
        8'd226, 8'd4,   8'd203, 8'd199, 8'd16,  8'd249, 8'd211, 8'd167,
        8'd55,  8'd255, 8'd254, 8'd116, 8'd122, 8'd13,  8'd236, 8'd93,
        8'd144, 8'd86,  8'd59,  8'd76,  8'd150, 8'd162, 8'd207, 8'd77,
        8'd176, 8'd32,  8'd124, 8'd171, 8'd29,  8'd45,  8'd30,  8'd67,
        8'd184, 8'd51,  8'd22,  8'd105, 8'd170, 8'd253, 8'd180, 8'd187,
        8'd130, 8'd156, 8'd98,  8'd159, 8'd220, 8'd40,  8'd133, 8'd135,
        8'd114, 8'd147, 8'd75,  8'd73,  8'd210, 8'd21,  8'd129, 8'd39,
        8'd138, 8'd91,  8'd41,  8'd235, 8'd47,  8'd185, 8'd9,   8'd82,
        8'd64,  8'd87,  8'd244, 8'd50,  8'd74,  8'd233, 8'd175, 8'd247,
        8'd120, 8'd6,   8'd169, 8'd85,  8'd66,  8'd104, 8'd80,  8'd71,
        8'd230, 8'd152, 8'd225, 8'd34,  8'd248, 8'd198, 8'd63,  8'd168,
        8'd179, 8'd141, 8'd137, 8'd5,   8'd19,  8'd79,  8'd232, 8'd128,
        8'd202, 8'd46,  8'd70,  8'd37,  8'd209, 8'd217, 8'd123, 8'd27,
        8'd177, 8'd25,  8'd56,  8'd65,  8'd229, 8'd36,  8'd197, 8'd234,
        8'd108, 8'd35,  8'd151, 8'd238, 8'd200, 8'd224, 8'd99,  8'd190
    };

    function automatic logic [7:0] pearson_fold(input logic [7:0] h, input logic [7:0] b);
        pearson_fold = PEARSON_ROM[h ^ b];
    endfunction

endpackage

`default_nettype wire

// ===== sv/ard_framer.sv =====
// Record framing state machine: phase, counters, field registers and running hash.
// Depends on ard_pkg; produces one t_result per accepted byte.
`default_nettype none

module ard_framer (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_wdata,
    output ard_pkg::t_result     o_result
);
    import ard_pkg::*;

    t_phase      r_phase,   n_phase;
    logic [47:0] r_count,   n_count;
    logic [23:0] r_mode,    n_mode;
    logic [15:0] r_plen,    n_plen;
    logic [47:0] r_clen,    n_clen;
    logic [7:0]  r_hash,    n_hash;
    logic [1:0]  r_error,   n_error;
    logic        r_check_hash;

    logic [47:0] count_inc;
    logic [7:0]  fold_hash;
    logic [2:0]  kind;
    logic        match;
    logic        mismatch_dir;

    assign count_inc    = r_count + 48'd1;
    assign fold_hash    = pearson_fold(r_hash, i_data_byte);
    assign mismatch_dir = (r_mode & TYPE_MASK) == TYPE_DIR;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_mode  = r_mode;
        n_plen  = r_plen;
        n_clen  = r_clen;
        n_hash  = r_hash;
        n_error = r_error;
        kind    = KIND_DROP;
        match   = 1'b0;
        unique case (r_phase)
            PH_MAGIC: begin
                kind = KIND_MAGIC;
                if (i_data_byte == MAGIC_BYTE) begin
                    n_mode  = '0;
                    n_plen  = '0;
                    n_clen  = '0;
                    n_hash  = pearson_fold(8'd0, i_data_byte);
                    n_count = '0;
                    n_phase = PH_HEADER;
                end else begin
                    n_error = ERR_MAGIC;
                    n_phase = PH_ERROR;
                end
            end
            PH_HEADER: begin
                kind   = KIND_HEADER;
                n_hash = fold_hash;
                if (r_count[3:0] < HDR_MODE_N) begin
                    n_mode = {r_mode[15:0], i_data_byte};
                end else if (r_count[3:0] < HDR_PLEN_N) begin
                    n_plen = {r_plen[7:0], i_data_byte};
                end else begin
                    n_clen = {r_clen[39:0], i_data_byte};
                end
                if (r_count[3:0] >= HDR_LAST) begin
                    n_count = '0;
                    if (r_plen != '0) begin
                        n_phase = PH_PATH;
                    end else if (n_clen != '0) begin
                        n_phase = PH_CONTENT;
                    end else begin
                        n_phase = PH_TRAILER;
                    end
                end else begin
                    n_count = count_inc;
                end
            end
            PH_PATH: begin
                kind    = KIND_PATH;
                n_hash  = fold_hash;
                n_count = count_inc;
                if (count_inc >= {32'd0, r_plen}) begin
                    n_count = '0;
                    n_phase = (r_clen != '0) ? PH_CONTENT : PH_TRAILER;
                end
            end
            PH_CONTENT: begin
                kind    = KIND_CONTENT;
                n_hash  = fold_hash;
                n_count = count_inc;
                if (count_inc >= r_clen) begin
                    n_count = '0;
                    n_phase = PH_TRAILER;
                end
            end
            PH_TRAILER: begin
                kind    = KIND_TRAILER;
                match   = (r_hash == i_data_byte);
                n_hash  = '0;
                n_count = '0;
                if (!match && r_check_hash && !mismatch_dir) begin
                    n_error = ERR_HASH;
                    n_phase = PH_ERROR;
                end else begin
                    n_phase = PH_MAGIC;
                end
            end
            default: begin
                kind    = KIND_DROP;
                n_phase = PH_ERROR;
            end
        endcase
    end

    always_comb begin
        o_result.byte_kind     = kind;
        o_result.byte_value    = i_data_byte;
        o_result.record_mode   = n_mode;
        o_result.path_len      = n_plen;
        o_result.content_len   = n_clen;
        o_result.is_directory  = (n_mode & TYPE_MASK) == TYPE_DIR;
        o_result.hash_match    = match;
        o_result.computed_hash = r_hash;
        o_result.error_code    = n_error;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_MAGIC;
            r_count      <= '0;
            r_mode       <= '0;
            r_plen       <= '0;
            r_clen       <= '0;
            r_hash       <= '0;
            r_error      <= ERR_NONE;
            r_check_hash <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_check_hash <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_phase <= n_phase;
                r_count <= n_count;
                r_mode  <= n_mode;
                r_plen  <= n_plen;
                r_clen  <= n_clen;
                r_hash  <= n_hash;
                r_error <= n_error;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/ard_out_buf.sv =====
// Two-entry result buffer between the framer and the output channel.
// Depends on ard_pkg for t_result; stalls the input only when both entries are full.
`default_nettype none

module ard_out_buf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire ard_pkg::t_result i_result,
    input  wire logic             i_out_stall,
    output logic                  o_full,
    output logic                  o_out_valid,
    output ard_pkg::t_result      o_result
);
    import ard_pkg::*;

    t_result     r_slot [2];
    logic        r_rd_ptr;
    logic        r_wr_ptr;
    logic [1:0]  r_fill;
    logic        pop;

    assign o_out_valid = r_fill != 2'd0;
    assign o_full      = r_fill == 2'd2;
    assign pop         = o_out_valid && !i_out_stall;
    assign o_result    = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= 1'b0;
            r_wr_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({i_push, pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/archive_record_deframer.sv =====
// Archive record deframer: top level joining the framer and the result buffer.
// Depends on ard_pkg, ard_framer and ard_out_buf.
//
// Input channel: i_data_byte with i_in_valid; the block drives o_in_stall. A request
// is taken at a rising edge with i_in_valid high and o_in_stall low.
// Output channel: one result request per input byte on the o_* fields with
// o_out_valid; the receiver drives i_out_stall.
// Configuration: i_cfg_we / i_cfg_wdata write check_hash (write only while idle).
// Output: each result is registered in the result buffer and leaves in byte order.
// Throughput: one byte per cycle while o_in_stall is low; the framing state machine
// updates phase, field registers and the Pearson hash (one table lookup) per byte.
// Stall: a two-entry result buffer keeps taking bytes while one result waits;
// o_in_stall rises only when both entries hold undelivered results.
// Reset (synchronous, active low): expects a magic byte, clears fields, hash,
// sticky error and check_hash, and empties the result buffer.
`default_nettype none

module archive_record_deframer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_byte_kind,
    output logic [7:0]       o_byte_value,
    output logic [23:0]      o_record_mode,
    output logic [15:0]      o_path_len,
    output logic [47:0]      o_content_len,
    output logic             o_is_directory,
    output logic             o_hash_match,
    output logic [7:0]       o_computed_hash,
    output logic [1:0]       o_error_code
);
    import ard_pkg::*;

    logic    in_accept;
    logic    buf_full;
    t_result frame_result;
    t_result out_result;

    assign o_in_stall = buf_full;
    assign in_accept  = i_in_valid && !buf_full;

    ard_framer u_framer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (frame_result)
    );

    ard_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_accept),
        .i_result    (frame_result),
        .i_out_stall (i_out_stall),
        .o_full      (buf_full),
        .o_out_valid (o_out_valid),
        .o_result    (out_result)
    );

    assign o_byte_kind     = out_result.byte_kind;
    assign o_byte_value    = out_result.byte_value;
    assign o_record_mode   = out_result.record_mode;
    assign o_path_len      = out_result.path_len;
    assign o_content_len   = out_result.content_len;
    assign o_is_directory  = out_result.is_directory;
    assign o_hash_match    = out_result.hash_match;
    assign o_computed_hash = out_result.computed_hash;
    assign o_error_code    = out_result.error_code;

`ifndef NO_ASSERTIONS
    a_stall_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty result buffer");

    a_drop_has_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_byte_kind == KIND_DROP) |-> (o_error_code != ERR_NONE))
        else $error("dropped byte without sticky error");

    a_match_on_trailer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hash_match) |-> (o_byte_kind == KIND_TRAILER))
        else $error("hash match flagged outside trailer");

    a_full_blocks_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_stall && i_out_stall) |=> o_in_stall)
        else $error("buffer lost an entry while output stalled");
`endif

endmodule

`default_nettype wire

// ===== sim/deframer_tb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the archive record deframer testbench: tracks record framing,
// the running Pearson hash and the sticky error, and checks every result request.
// Depends on ard_pkg (codes, phase enum, result struct, permutation table).

package deframer_tb_pkg;
    import ard_pkg::*;

    class deframer_scoreboard;
        t_phase      stage;
        logic [47:0] count;
        logic [23:0] mode;
        logic [15:0] plen;
        logic [47:0] clen;
        logic [7:0]  running_hash;
        logic [1:0]  err;
        logic        check_on;
        t_result     tags_due[$];
        int unsigned n_bytes, n_trailers, n_matched, n_dropped, n_fail;

        function new();
            stage = PH_MAGIC;
            count = '0;
            mode = '0;
            plen = '0;
            clen = '0;
            running_hash = '0;
            err = ERR_NONE;
            check_on = 1'b0;
            n_bytes = 0;
            n_trailers = 0;
            n_matched = 0;
            n_dropped = 0;
            n_fail = 0;
        endfunction

        function bit is_dir();
            return (mode & TYPE_MASK) == TYPE_DIR;
        endfunction

        function int pending();
            return tags_due.size();
        endfunction

        // Frame one accepted byte request and queue the tag it must produce.
        function void tag_byte(logic [7:0] b);
            t_result    tag;
            logic [7:0] prior;
            logic       match;
            prior = running_hash;
            match = 1'b0;
            tag.byte_kind = KIND_DROP;
            case (stage)
                PH_MAGIC: begin
                    tag.byte_kind = KIND_MAGIC;
                    if (b == MAGIC_BYTE) begin
                        mode = '0;
                        plen = '0;
                        clen = '0;
                        running_hash = PEARSON_ROM[b];
                        count = '0;
                        stage = PH_HEADER;
                    end else begin
                        err = ERR_MAGIC;
                        stage = PH_ERROR;
                    end
                end
                PH_HEADER: begin
                    tag.byte_kind = KIND_HEADER;
                    if (count < HDR_MODE_N) begin
                        mode = {mode[15:0], b};
                    end else if (count < HDR_PLEN_N) begin
                        plen = {plen[7:0], b};
                    end else begin
                        clen = {clen[39:0], b};
                    end
                    running_hash = PEARSON_ROM[running_hash ^ b];
                    if (count >= HDR_LAST) begin
                        count = '0;
                        if (plen != 0) stage = PH_PATH;
                        else if (clen != 0) stage = PH_CONTENT;
                        else stage = PH_TRAILER;
                    end else begin
                        count = count + 1;
                    end
                end
                PH_PATH: begin
                    tag.byte_kind = KIND_PATH;
                    running_hash = PEARSON_ROM[running_hash ^ b];
                    count = count + 1;
                    if (count >= plen) begin
                        count = '0;
                        stage = (clen != 0) ? PH_CONTENT : PH_TRAILER;
                    end
                end
                PH_CONTENT: begin
                    tag.byte_kind = KIND_CONTENT;
                    running_hash = PEARSON_ROM[running_hash ^ b];
                    count = count + 1;
                    if (count >= clen) begin
                        count = '0;
                        stage = PH_TRAILER;
                    end
                end
                PH_TRAILER: begin
                    tag.byte_kind = KIND_TRAILER;
                    match = (prior == b);
                    running_hash = '0;
                    count = '0;
                    n_trailers++;
                    if (match) n_matched++;
                    if (!match && check_on && !is_dir()) begin
                        err = ERR_HASH;
                        stage = PH_ERROR;
                    end else begin
                        stage = PH_MAGIC;
                    end
                end
                default: begin
                    tag.byte_kind = KIND_DROP;
                    stage = PH_ERROR;
                    n_dropped++;
                end
            endcase
            tag.byte_value = b;
            tag.record_mode = mode;
            tag.path_len = plen;
            tag.content_len = clen;
            tag.is_directory = is_dir();
            tag.hash_match = match;
            tag.computed_hash = prior;
            tag.error_code = err;
            tags_due.push_back(tag);
            n_bytes++;
        endfunction

        function void compare_field(string name, logic [47:0] want, logic [47:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                n_fail++;
            end
        endfunction

        function void check_tag(t_result got);
            t_result want;
            if (tags_due.size() == 0) begin
                $error("result request with no byte pending (kind %0d)", got.byte_kind);
                n_fail++;
                return;
            end
            want = tags_due.pop_front();
            compare_field("byte_kind", want.byte_kind, got.byte_kind);
            compare_field("byte_value", want.byte_value, got.byte_value);
            compare_field("record_mode", want.record_mode, got.record_mode);
            compare_field("path_len", want.path_len, got.path_len);
            compare_field("content_len", want.content_len, got.content_len);
            compare_field("is_directory", want.is_directory, got.is_directory);
            compare_field("hash_match", want.hash_match, got.hash_match);
            compare_field("computed_hash", want.computed_hash, got.computed_hash);
            compare_field("error_code", want.error_code, got.error_code);
        endfunction
    endclass

endpackage

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Top-level testbench for archive_record_deframer: drives framed archive records
// with random gaps and stalls, and checks every result request against the scoreboard.
// Depends on ard_pkg, deframer_tb_pkg and the deframer RTL.

module testbench;
    import ard_pkg::*;
    import deframer_tb_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam logic [23:0] REG_FILE_TYPE = 24'o100000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_byte_kind;
    logic [7:0]  o_byte_value;
    logic [23:0] o_record_mode;
    logic [15:0] o_path_len;
    logic [47:0] o_content_len;
    logic        o_is_directory;
    logic        o_hash_match;
    logic [7:0]  o_computed_hash;
    logic [1:0]  o_error_code;

    deframer_scoreboard sb;
    t_result     seen;
    bit          steady = 1'b0;
    int unsigned n_sent = 0;
    int unsigned cycle_count = 0;

    archive_record_deframer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_byte_kind     (o_byte_kind),
        .o_byte_value    (o_byte_value),
        .o_record_mode   (o_record_mode),
        .o_path_len      (o_path_len),
        .o_content_len   (o_content_len),
        .o_is_directory  (o_is_directory),
        .o_hash_match    (o_hash_match),
        .o_computed_hash (o_computed_hash),
        .o_error_code    (o_error_code)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench failed");
            $finish;
        end
    end

    always @(negedge i_clk)
        i_out_stall <= !steady && ($urandom_range(0, 99) < 13);

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.byte_kind = o_byte_kind;
            seen.byte_value = o_byte_value;
            seen.record_mode = o_record_mode;
            seen.path_len = o_path_len;
            seen.content_len = o_content_len;
            seen.is_directory = o_is_directory;
            seen.hash_match = o_hash_match;
            seen.computed_hash = o_computed_hash;
            seen.error_code = o_error_code;
            sb.check_tag(seen);
        end
    end

    function automatic logic [15:0] pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25) return 16'd0;
        if (r < 85) return 16'($urandom_range(1, 8));
        if (r < 99) return 16'($urandom_range(9, 40));
        return 16'($urandom_range(256, 300));
    endfunction

    // One byte request; holds until accepted.
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < 13) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        sb.tag_byte(b);
        n_sent++;
    endtask

    task automatic park_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic write_check(input logic v);
        park_input();
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.check_on = v;
    endtask

    task automatic send_header(input logic [23:0] mode, input logic [15:0] plen,
                               input logic [47:0] clen);
        logic [87:0] fields;
        fields = {mode, plen, clen};
        send_byte(MAGIC_BYTE);
        for (int i = 0; i < 11; i++) send_byte(fields[87 - 8 * i -: 8]);
    endtask

    task automatic send_record(input logic [23:0] mode, input logic [15:0] plen,
                               input logic [47:0] clen, input logic spoil);
        logic [7:0] trailer;
        send_header(mode, plen, clen);
        for (int unsigned k = 0; k < plen; k++) send_byte(8'($urandom_range(0, 255)));
        for (longint unsigned k = 0; k < clen; k++) send_byte(8'($urandom_range(0, 255)));
        trailer = sb.running_hash;
        if (spoil) trailer = trailer ^ 8'($urandom_range(1, 255));
        send_byte(trailer);
    endtask

    initial begin
        logic [23:0] mode;
        logic [15:0] plen;
        logic [47:0] clen;
        bit          as_dir;
        int unsigned goal;
        int unsigned finale;
        string       finale_note;

        sb = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty path and content, trailer mismatch in list mode
        send_record(24'hFFFFFF, 16'd0, 48'd0, 1'b1);
        // directory with one path byte and one content byte at the byte extremes
        send_header(TYPE_DIR, 16'd1, 48'd1);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(sb.running_hash);

        for (int ph = 0; ph < 8; ph++) begin
            write_check(ph[0]);
            steady = (ph == 3);
            goal = n_sent + 100;
            while (n_sent < goal) begin
                as_dir = $urandom_range(0, 99) < 35;
                mode = 24'($urandom);
                if (as_dir) mode = (mode & ~TYPE_MASK) | TYPE_DIR;
                plen = pick_len();
                clen = 48'(pick_len());
                // under checking only directories may carry a bad hash
                send_record(mode, plen, clen,
                            (as_dir || !ph[0]) && $urandom_range(0, 99) < 30);
            end
        end
        steady = 1'b0;

        // sticky errors end the useful stream, so one ending per run
        write_check(1'b1);
        finale = $urandom_range(0, 2);
        case (finale)
            0: begin
                finale_note = "bad magic byte";
                send_byte(MAGIC_BYTE ^ 8'($urandom_range(1, 255)));
            end
            1: begin
                finale_note = "hash mismatch under checking";
                send_record((24'($urandom) & ~TYPE_MASK) | REG_FILE_TYPE, pick_len(),
                            48'(pick_len()), 1'b1);
            end
            default: begin
                finale_note = "record with all-ones lengths";
                send_header(24'hFFFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
            end
        endcase
        repeat (24) send_byte(8'($urandom_range(0, 255)));

        park_input();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("%0d bytes in %0d cycles: %0d trailers, %0d hash matches, %0d dropped",
                 sb.n_bytes, cycle_count, sb.n_trailers, sb.n_matched, sb.n_dropped);
        $display("check_hash run at 0 and 1; ending: %s", finale_note);
        if (sb.n_fail == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ard_pkg.sv
sv/ard_framer.sv
sv/ard_out_buf.sv
sv/archive_record_deframer.sv
sim/deframer_tb_pkg.sv
sim/testbench.sv
